>>> rtl/float32_add_sub_mul_div_unit_assert.svh
// assertion macros for the float32 arithmetic unit
`ifndef FLOAT32_ADD_SUB_MUL_DIV_UNIT_ASSERT_SVH
`define FLOAT32_ADD_SUB_MUL_DIV_UNIT_ASSERT_SVH
`define F32U_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define F32U_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/f32u_pkg.sv
// package for the float32 arithmetic unit
`default_nettype none
package f32u_pkg;
   localparam int DivStepsDefault = 47;
   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;
   typedef struct packed {
      logic mul_done;
      logic norm_done;
      logic div_done;
      logic [1:0] mode;
   } stat_type;
endpackage
`default_nettype wire

>>> rtl/f32u_datapath.sv
// datapath: unpack, align, add, multiply, normalize and divide iterations
`default_nettype none
module f32u_datapath
   import f32u_pkg::*;
#(
   parameter int DIV_STEPS = DivStepsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   input  wire logic [1:0]  mode,
   output logic [31:0]      result
);
   localparam int CW = $clog2(DIV_STEPS + 1);
   logic [1:0]  mode_ff, mode_in;
   logic        s_ff, s_in;
   logic [7:0]  ea_ff, ea_in, eb_ff, eb_in;
   logic [9:0]  e_ff, e_in;
   logic [24:0] v_ff, v_in;
   logic [23:0] mb_ff, mb_in;
   logic [31:0] rem_ff, rem_in;
   logic        zero_ff, zero_in, big_ff, big_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [2:0]  ph_ff, ph_in;
   logic [47:0] p_ff, p_in;
   logic [31:0] res_ff, res_in;
   logic        sa, sb, sbe, swap, sub;
   logic [7:0]  ea, eb, gx, sx, d;
   logic [23:0] ma, mb, gm, sm, sh;
   logic [31:0] t, dd;
   logic [8:0]  sum;
   logic        i;

   always_comb begin
      sa = a[31]; ea = a[30:23]; ma = {1'b1, a[22:0]};
      sb = b[31]; eb = b[30:23]; mb = {1'b1, b[22:0]};
      sbe = (mode == MODE_SUB) ? ~sb : sb;
      swap = {ea, ma} < {eb, mb};
      gx = swap ? eb : ea; gm = swap ? mb : ma;
      sx = swap ? ea : eb; sm = swap ? ma : mb;
      d = gx - sx;
      sh = sm >> d[4:0];
      sub = sa != sbe;
      mode_in = mode_ff; s_in = s_ff; ea_in = ea_ff; eb_in = eb_ff; e_in = e_ff;
      v_in = v_ff; mb_in = mb_ff; rem_in = rem_ff; zero_in = zero_ff; big_in = big_ff;
      cnt_in = cnt_ff; ph_in = ph_ff; p_in = p_ff; res_in = res_ff;
      t = {rem_ff[30:0], v_ff[23]};
      dd = t - {8'd0, mb_ff};
      sum = {1'b0, ea_ff} + {1'b0, eb_ff};
      i = p_ff[47];
      if (cmd.load) begin
         mode_in = mode; cnt_in = '0; ph_in = '0; rem_in = '0;
         ea_in = ea; eb_in = eb; mb_in = mb;
         zero_in = 1'b0; big_in = d >= 8'd24;
         if (mode == MODE_DIV || mode == MODE_MUL) begin
            s_in = sa ^ sb; v_in = {1'b0, ma};
            zero_in = (ea == 0 && a[22:0] == 0) || (eb == 0 && b[22:0] == 0);
         end else begin
            s_in = swap ? sbe : sa; e_in = {2'b0, gx};
            if (big_in) v_in = {1'b0, gm};
            else if (sub) v_in = {1'b0, gm} - {1'b0, sh};
            else v_in = {1'b0, gm} + {1'b0, sh};
            mode_in = sub ? MODE_SUB : MODE_ADD;
            zero_in = sub && !big_in && gm == sh;
         end
      end else if (cmd.step) begin
         unique case (mode_ff)
            MODE_ADD: if (!big_ff && v_ff[24]) begin
               v_in = v_ff >> 1; e_in = {2'b0, e_ff[7:0] + 8'd1};
            end
            MODE_SUB: if (!big_ff && !zero_ff && !v_ff[23] && e_ff != 0) begin
               v_in = v_ff << 1; e_in = e_ff - 10'd1;
            end
            MODE_MUL: begin
               ph_in = ph_ff + 3'd1;
               if (ph_ff == 0) p_in = v_ff[23:0] * mb_ff;
            end
            MODE_DIV: begin
               v_in = {1'b0, v_ff[22:0], ~dd[31]};
               rem_in = dd[31] ? t : dd;
               cnt_in = cnt_ff + 1'b1;
            end
            default: ;
         endcase
      end else if (cmd.finish) begin
         unique case (mode_ff)
            MODE_ADD, MODE_SUB: res_in = zero_ff ? 32'd0 :
               {s_ff, e_ff[7:0], v_ff[22:0]};
            MODE_MUL:
               if (zero_ff) res_in = 32'd0;
               else if (sum > 9'h07E && sum < 9'h17F)
                  res_in = {s_ff, 8'(sum - 9'd127 + {8'd0, i}),
                            (i ? p_ff[46:24] : p_ff[45:23])};
               else res_in = {s_ff, 31'h7FFFFFFF};
            default:
               if (v_ff[23]) res_in = {s_ff, 8'(ea_ff + 8'd127 - eb_ff), v_ff[22:0]};
               else res_in = {s_ff, 8'(ea_ff + 8'd126 - eb_ff), v_ff[21:0], 1'b0};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in; s_ff <= s_in; ea_ff <= ea_in; eb_ff <= eb_in; e_ff <= e_in;
      v_ff <= v_in; mb_ff <= mb_in; rem_ff <= rem_in; zero_ff <= zero_in;
      big_ff <= big_in; cnt_ff <= cnt_in; ph_ff <= ph_in; p_ff <= p_in; res_ff <= res_in;
   end

   assign stat.mode = mode_ff;
   assign stat.mul_done = ph_ff != 0;
   assign stat.norm_done = big_ff || zero_ff || (mode_ff == MODE_ADD) ||
                           v_ff[23] || e_ff == 0;
   assign stat.div_done = cnt_ff == CW'(DIV_STEPS);
   assign result = res_ff;
   logic unused;
   assign unused = reset;
endmodule
`default_nettype wire

>>> rtl/f32u_control.sv
// controller state machine for the float32 arithmetic unit
`default_nettype none
module f32u_control
   import f32u_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output cmd_type       cmd,
   input  wire stat_type stat
);
`include "float32_add_sub_mul_div_unit_assert.svh"
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_RUN = 4'b0010, ST_FIN = 4'b0100, ST_OUT = 4'b1000
   } state_type;
   state_type state_ff, state_in;
   logic done;
   always_comb begin
      case (stat.mode)
         MODE_ADD: done = 1'b0;
         MODE_SUB: done = stat.norm_done;
         MODE_MUL: done = stat.mul_done;
         default:  done = stat.div_done;
      endcase
   end
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin cmd.load = 1'b1; state_in = ST_RUN; end
         ST_RUN: begin
            cmd.step = !done;
            if (done || stat.mode == MODE_ADD) state_in = ST_FIN;
         end
         ST_FIN: begin cmd.finish = 1'b1; state_in = ST_OUT; end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;
   `F32U_ASSERT_IMPL(a_excl, req_ready, !rsp_valid)
   `F32U_ASSERT_NEXT(a_load, req_valid && req_ready, state_ff == ST_RUN)
   `F32U_ASSERT_NEXT(a_fin, state_ff == ST_FIN, rsp_valid)
endmodule
`default_nettype wire

>>> rtl/float32_add_sub_mul_div_unit.sv
// top level of the float32 add, subtract, multiply and divide unit
//   channel | ports               | direction
//   req     | operand_a/b, mode   | in
//   rsp     | result              | out
// one item at a time; add and subtract normalize by shifts, divide runs DIV_STEPS
// iterations (one quotient bit per cycle in the divider loop)
// synchronous reset returns the controller to idle; result held until taken
`default_nettype none
module float32_add_sub_mul_div_unit
   import f32u_pkg::*;
#(
   parameter int DIV_STEPS = DivStepsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_operand_a,
   input  wire logic [31:0] req_operand_b,
   input  wire logic [1:0]  req_mode,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_result
);
   cmd_type  cmd;
   stat_type stat;
   f32u_control u_ctl (.clock, .reset, .req_valid, .req_ready, .rsp_valid,
      .rsp_ready, .cmd, .stat);
   f32u_datapath #(.DIV_STEPS(DIV_STEPS)) u_dp (.clock, .reset, .cmd, .stat,
      .a(req_operand_a), .b(req_operand_b), .mode(req_mode), .result(rsp_result));
endmodule
`default_nettype wire

>>> test/float32_add_sub_mul_div_unit_tb.sv
// testbench for the float32 add, subtract, multiply and divide unit
`timescale 1ns / 1ps
`default_nettype none
module float32_add_sub_mul_div_unit_tb;
   import f32u_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int RandomItems = 850;
   localparam int DivSteps = DivStepsDefault;

   typedef struct {
      logic [31:0] a;
      logic [31:0] b;
      logic [1:0] mode;
      logic known;
      logic [31:0] result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic [1:0] req_mode = MODE_ADD;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_result;

   logic [31:0] expected_results[$];
   int mismatch_count = 0;
   int result_count = 0;
   int cycle_count = 0;
   int mode_count[4] = '{0, 0, 0, 0};
   bit sender_done = 1'b0;

   float32_add_sub_mul_div_unit #(.DIV_STEPS(DivSteps)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .req_mode(req_mode),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result(rsp_result)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] pack_float(logic s, logic [7:0] e, logic [23:0] m);
      return {s, e, m[22:0]};
   endfunction

   function automatic logic [31:0] add_sub_magnitudes(logic sa, logic [7:0] ea, logic [23:0] ma,
                                                      logic sb, logic [7:0] eb, logic [23:0] mb,
                                                      logic subtract);
      logic s;
      logic [7:0] e;
      logic [7:0] gap;
      logic [24:0] v;
      logic [23:0] d;
      if ({ea, ma} < {eb, mb}) begin
         s = sa; sa = sb; sb = s;
         e = ea; ea = eb; eb = e;
         d = ma; ma = mb; mb = d;
      end
      gap = ea - eb;
      if (gap >= 8'd24) return pack_float(sa, ea, ma);
      e = ea;
      if (!subtract) begin
         v = {1'b0, ma} + {1'b0, mb >> gap};
         if (v[24]) begin
            v = v >> 1;
            e = e + 8'd1;
         end
         return pack_float(sa, e, v[23:0]);
      end
      d = ma - (mb >> gap);
      if (d == '0) return '0;
      while (!d[23] && e > 0) begin
         e = e - 8'd1;
         d = d << 1;
      end
      return pack_float(sa, e, d);
   endfunction

   function automatic logic [31:0] truncated_float_result(logic [31:0] a, logic [31:0] b,
                                                          logic [1:0] mode);
      logic sa, sb;
      logic [7:0] ea, eb;
      logic [23:0] ma, mb, quot;
      logic [47:0] prod;
      logic [9:0] esum;
      logic [31:0] rem, t, dd;
      logic carry;
      sa = a[31];
      sb = b[31];
      ea = a[30:23];
      eb = b[30:23];
      ma = {1'b1, a[22:0]};
      mb = {1'b1, b[22:0]};
      case (mode)
         MODE_ADD: return add_sub_magnitudes(sa, ea, ma, sb, eb, mb, sa != sb);
         MODE_SUB: return add_sub_magnitudes(sa, ea, ma, ~sb, eb, mb, sa == sb);
         MODE_MUL: begin
            if ((ea == 0 && a[22:0] == 0) || (eb == 0 && b[22:0] == 0)) return '0;
            prod = ma * mb;
            carry = prod[47];
            esum = ea + eb;
            if (esum > 10'd126 && esum < 10'd383)
               return pack_float(sa ^ sb, 8'(esum - 10'd127 + {9'd0, carry}),
                                 carry ? prod[47:24] : prod[46:23]);
            return {sa ^ sb, 31'h7FFFFFFF};
         end
         default: begin
            quot = ma;
            rem = '0;
            for (int k = 0; k < DivSteps; k++) begin
               t = (rem << 1) + quot[23];
               dd = t - mb;
               quot = quot << 1;
               if (!dd[31]) begin
                  rem = dd;
                  quot[0] = 1'b1;
               end else begin
                  rem = t;
               end
            end
            if (quot[23]) return pack_float(sa ^ sb, ea + 8'd127 - eb, quot);
            return pack_float(sa ^ sb, ea + 8'd127 - eb - 8'd1, quot << 1);
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   task automatic send_item(logic [31:0] a, logic [31:0] b, logic [1:0] mode);
      req_valid <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      req_mode <= mode;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mode_count[mode]++;
   endtask

   task automatic queue_and_send(logic [31:0] a, logic [31:0] b, logic [1:0] mode);
      expected_results.push_back(truncated_float_result(a, b, mode));
      send_item(a, b, mode);
   endtask

   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0: v[30:23] = 8'd127 + 8'($urandom_range(0, 6)) - 8'd3;
         1: v[30:23] = $urandom_range(0, 1) ? 8'd0 : 8'd255;
         2: v[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7FFFFF;
         default: ;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("float32_add_sub_mul_div_unit_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_result, 'x);
         end else begin
            logic [31:0] want;
            want = expected_results.pop_front();
            if (rsp_result !== want) report_mismatch("result", rsp_result, want);
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if ((cycle_count / 64) % 4 == 3) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   stim_row_type directed_rows[] = '{
      '{32'h3F800000, 32'h3F800000, MODE_ADD, 1'b1, 32'h40000000},
      '{32'h3F800000, 32'h3F800000, MODE_SUB, 1'b1, 32'h00000000},
      '{32'hBF800000, 32'h3F800000, MODE_ADD, 1'b1, 32'h00000000},
      '{32'h3F800000, 32'h3F800000, MODE_MUL, 1'b1, 32'h3F800000},
      '{32'h40000000, 32'h3F800000, MODE_DIV, 1'b1, 32'h40000000},
      '{32'h4B800000, 32'h3F800000, MODE_ADD, 1'b1, 32'h4B800000},
      '{32'h3F800000, 32'h4B800000, MODE_SUB, 1'b0, 32'h0},
      '{32'h00000000, 32'h40400000, MODE_MUL, 1'b1, 32'h00000000},
      '{32'hC0400000, 32'h80000000, MODE_MUL, 1'b1, 32'h00000000},
      '{32'h7F000000, 32'h7F000000, MODE_MUL, 1'b1, 32'h7FFFFFFF},
      '{32'h80800000, 32'h00800000, MODE_MUL, 1'b1, 32'hFFFFFFFF},
      '{32'h7F7FFFFF, 32'h7F7FFFFF, MODE_MUL, 1'b0, 32'h0},
      '{32'h7F800000, 32'h3F800000, MODE_MUL, 1'b0, 32'h0},
      '{32'h7F7FFFFF, 32'h7F7FFFFF, MODE_ADD, 1'b0, 32'h0},
      '{32'h00000000, 32'h00000000, MODE_ADD, 1'b0, 32'h0},
      '{32'h00000001, 32'h00000000, MODE_SUB, 1'b0, 32'h0},
      '{32'h00800000, 32'h00000000, MODE_SUB, 1'b0, 32'h0},
      '{32'hFFFFFFFF, 32'h00000000, MODE_DIV, 1'b0, 32'h0},
      '{32'h00000000, 32'hFFFFFFFF, MODE_DIV, 1'b0, 32'h0},
      '{32'h3F800000, 32'h3FFFFFFF, MODE_DIV, 1'b0, 32'h0},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, MODE_SUB, 1'b0, 32'h0},
      '{32'h3FFFFFFF, 32'h3F800001, MODE_SUB, 1'b0, 32'h0}
   };

   initial begin
      logic [1:0] mode;
      int burst;
      int sent;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         expected_results.push_back(directed_rows[i].known ? directed_rows[i].result
            : truncated_float_result(directed_rows[i].a, directed_rows[i].b,
                                     directed_rows[i].mode));
         send_item(directed_rows[i].a, directed_rows[i].b, directed_rows[i].mode);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      sent = 0;
      while (sent < RandomItems) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < RandomItems; k++) begin
            logic [31:0] a, b;
            mode = 2'($urandom_range(0, 3));
            a = random_operand();
            b = random_operand();
            if (mode <= MODE_SUB && $urandom_range(0, 2) == 0) begin
               b = a ^ 32'($urandom_range(0, 7));
               if ($urandom_range(0, 1)) b[31] = ~b[31];
            end
            queue_and_send(a, b, mode);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
         if (sent == RandomItems / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_results.size() != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d results: %0d add, %0d subtract, %0d multiply, %0d divide",
               result_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
      $display("directed corners plus random operands with bursty input and a stalling output");
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("float32_add_sub_mul_div_unit_tb: PASS");
      end else begin
         $display("float32_add_sub_mul_div_unit_tb: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> float32_add_sub_mul_div_unit.f
+incdir+rtl
rtl/f32u_pkg.sv
rtl/f32u_datapath.sv
rtl/f32u_control.sv
rtl/float32_add_sub_mul_div_unit.sv
test/float32_add_sub_mul_div_unit_tb.sv
